[hw/rtl/acmac_pkg.sv]
// Shared types, constants and AES helper functions for the CMAC tag engine.
package acmac_pkg;

  localparam int BlkW   = 128;
  localparam int CntW   = 5;
  localparam int QDepth = 2;
  localparam logic [7:0] CmacRb  = 8'h87;
  localparam logic [7:0] CmacPad = 8'h80;

  localparam logic CfgKeyUpper = 1'b0;

  // Job handed from the block assembler to the cipher side
  typedef enum logic [1:0] {
    JOB_ABSORB = 2'b01,
    JOB_FINAL  = 2'b10
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [BlkW-1:0]  blk;
    logic             full;
  } job_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // S-box as a constant table
  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = tbl[x];
  endfunction

  // Byte i of a block sits at bits 127-8i
  function automatic logic [BlkW-1:0] aes_round(input logic [BlkW-1:0] s,
                                                input logic [BlkW-1:0] rk,
                                                input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [BlkW-1:0] o;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[BlkW-1-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[r+4*c] = b[r+4*((c+r)%4)];
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
      m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
    end
    for (int i = 0; i < 16; i++) o[BlkW-1-8*i -: 8] = last ? t[i] : m[i];
    aes_round = o ^ rk;
  endfunction

  // Next round key from the current one
  function automatic logic [BlkW-1:0] key_step(input logic [BlkW-1:0] k,
                                               input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, g;
    {w0, w1, w2, w3} = k;
    g = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ g;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

  function automatic logic [BlkW-1:0] dbl(input logic [BlkW-1:0] x);
    dbl = {x[BlkW-2:0], 1'b0} ^ {{(BlkW-8){1'b0}}, (x[BlkW-1] ? CmacRb : 8'h00)};
  endfunction

endpackage

[hw/rtl/acmac_front.sv]
// Byte assembler: builds 16-byte blocks and issues absorb / final jobs.
module acmac_front import acmac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  logic [BlkW-1:0] buf_r, buf_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            pend_r, pend_nxt;
  logic            pres;
  logic            acc;
  logic            absorb_now;
  logic [BlkW-1:0] fin_blk;
  logic [BlkW-1:0] base;
  logic [CntW-1:0] cnt_mid;

  // While a final is pending no request is taken and no byte enters the buffer
  assign pres       = byte_present && !pend_r;
  // A new byte on a full buffer pushes an absorb; end of message pushes a final.
  assign absorb_now = pres && (cnt_r == CntW'(16));
  assign in_tready  = job_ready && !pend_r;
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    base    = absorb_now ? '0 : buf_r;
    cnt_mid = absorb_now ? '0 : cnt_r;
    buf_nxt = base;
    if (pres) buf_nxt[BlkW-1-8*cnt_mid[3:0] -: 8] = data_byte;
    cnt_nxt = cnt_mid + CntW'(pres);
    // pad the partial block
    fin_blk = buf_nxt;
    if (cnt_nxt != CntW'(16)) fin_blk[BlkW-1-8*cnt_nxt[3:0] -: 8] = CmacPad;
    for (int i = 0; i < 16; i++)
      if (i > cnt_nxt) fin_blk[BlkW-1-8*i -: 8] = 8'h00;
  end

  // One job per cycle while job_ready is high: a pending final goes first, then absorb, then final
  always_comb begin
    job_valid = 1'b0;
    job.kind  = JOB_FINAL;
    job.blk   = fin_blk;
    job.full  = (cnt_nxt == CntW'(16));
    if (pend_r) begin
      job_valid = 1'b1;
    end else if (in_tvalid && absorb_now) begin
      job_valid = 1'b1;
      job.kind  = JOB_ABSORB;
      job.blk   = buf_r;
    end else if (in_tvalid && end_of_message) begin
      job_valid = 1'b1;
    end
  end

  // absorb+final in one request: absorb this cycle, final from the buffer once pend_r is set
  always_comb begin
    pend_nxt = pend_r;
    if (acc && absorb_now && end_of_message) pend_nxt = 1'b1;
    if (pend_r && job_ready) pend_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (pend_r && job_ready) cnt_r <= '0;
      else if (acc)            cnt_r <= (end_of_message && !absorb_now) ? '0 : cnt_nxt;
    end
    if (acc) buf_r <= buf_nxt;
  end

endmodule

[hw/rtl/acmac_queue.sv]
// Two-entry job queue between the assembler and the cipher side.
module acmac_queue import acmac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic clr,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  job_t       mem_r [QDepth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_job;
  end

`ifndef SYNTHESIS
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");
  a_empty_nord: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !rd) else $error("read from empty queue");
  a_full_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !wr) else $error("write to full queue");
`endif

endmodule

[hw/rtl/acmac_back.sv]
// Cipher side: iterative AES-128, subkey generation, chaining and tag output.
module acmac_back import acmac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic [BlkW-1:0]   key,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BlkW-1:0]   out_tag
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SUBK  = 4'b0010,
    S_ENC   = 4'b0100,
    S_OUT   = 4'b1000
  } st_t;

  st_t             st_r;
  logic [BlkW-1:0] cv_r, st_blk_r, rk_r, l_r;
  logic [7:0]      rc_r;
  logic [3:0]      rnd_r;
  logic            skr_r, fin_r;
  logic [BlkW-1:0] rk_n, st_n, k1, k2, fin_in;

  assign rk_n = key_step(rk_r, rc_r);
  assign st_n = aes_round(st_blk_r, rk_n, rnd_r == 4'd10);
  assign k1   = dbl(l_r);
  assign k2   = dbl(k1);
  assign fin_in = job.blk ^ cv_r ^ (job.full ? k1 : k2);

  assign job_ready = (st_r == S_IDLE) && !(job.kind == JOB_FINAL && !skr_r);

  // Sequencer: ten rounds per block, round keys expanded on the fly
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      st_r  <= S_IDLE;
      skr_r <= 1'b0;
      cv_r  <= '0;
      out_tvalid <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (job_valid && !skr_r && job.kind == JOB_FINAL) begin
            st_blk_r <= key;
            rk_r     <= key;
            rc_r     <= 8'h01;
            rnd_r    <= 4'd1;
            st_r     <= S_SUBK;
          end else if (job_valid) begin
            st_blk_r <= ((job.kind == JOB_ABSORB) ? (job.blk ^ cv_r) : fin_in) ^ key;
            rk_r     <= key;
            rc_r     <= 8'h01;
            rnd_r    <= 4'd1;
            fin_r    <= (job.kind == JOB_FINAL);
            st_r     <= S_ENC;
          end
        end
        S_SUBK, S_ENC: begin
          st_blk_r <= st_n;
          rk_r     <= rk_n;
          rc_r     <= xtime(rc_r);
          rnd_r    <= rnd_r + 4'd1;
          if (rnd_r == 4'd10) begin
            if (st_r == S_SUBK) begin
              l_r   <= st_n;
              skr_r <= 1'b1;
              st_r  <= S_IDLE;
            end else if (fin_r) begin
              cv_r       <= '0;
              out_tvalid <= 1'b1;
              st_r       <= S_OUT;
            end else begin
              cv_r <= st_n;
              st_r <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            st_r       <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tag = st_blk_r;

`ifndef SYNTHESIS
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st_r == S_OUT)) else $error("tag valid outside output state");
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ENC) |-> (rnd_r >= 4'd1 && rnd_r <= 4'd10)) else $error("round out of range");
  a_subk_first: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job_ready && job.kind == JOB_FINAL) |-> skr_r)
    else $error("final without subkey");
`endif

endmodule

[hw/rtl/aes_cmac_tag_top.sv]
// Top level of the AES-128 CMAC tag engine.
//  channel | dir | tdata (low bit up)              | tuser        | tlast
//  in_     | in  | data_byte[7:0]                  | byte_present | end_of_message
//  out_    | out | tag_upper[63:0], tag_lower[127:64] | -         | -
//  cfg_    | in  | index 0 key_upper, 1 key_lower (64 bit) | -     | -
// One byte a cycle is taken while in_tready is high; each full block passes through the
// iterative AES round unit, the first tag after reset or a key write also the subkey.
// A byte that lands on a full buffer and ends the message drops in_tready
// while its final block follows the absorb into the queue.
// Reset (rst_n low, synchronous) and key writes clear chaining and counts.
// The two-entry job queue stalls in_tready when the round unit lags; a pending final also stalls it.
module aes_cmac_tag_top import acmac_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // byte_present
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // tag_upper, tag_lower
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_wdata
);

  logic [63:0]     key_hi_r, key_lo_r;
  logic            clr;
  logic            fq_valid, fq_ready, bq_valid, bq_ready;
  job_t            fq_job, bq_job;
  logic [BlkW-1:0] tag;

  assign clr = cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CfgKeyUpper) key_hi_r <= cfg_wdata;
      else                          key_lo_r <= cfg_wdata;
    end
  end

  acmac_front u_front (
    .clk, .rst_n, .clr,
    .in_tvalid, .in_tready,
    .data_byte(in_tdata), .byte_present(in_tuser),
    .end_of_message(in_tlast),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  acmac_queue u_queue (
    .clk, .rst_n, .clr,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_job(bq_job)
  );

  acmac_back u_back (
    .clk, .rst_n, .clr, .key({key_hi_r, key_lo_r}),
    .job_valid(bq_valid), .job_ready(bq_ready), .job(bq_job),
    .out_tvalid, .out_tready, .out_tag(tag)
  );

  // tag_upper in the low half, tag_lower in the high half
  assign out_tdata = {tag[63:0], tag[127:64]};

endmodule

[bench/aes_cmac_tag_checker.sv]
// Result checker for the CMAC tag engine: watches the channels, predicts tags, compares.
module aes_cmac_tag_checker import acmac_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_wdata,
  output int           fail_count,
  output int           tags_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predictor state
  logic [127:0] aes_key;
  logic [127:0] chain;
  logic [7:0]   msg_blk [16];
  int           nbuf;
  logic [127:0] l_base;
  bit           l_valid;
  logic [127:0] tag_q [$];

  // GF(2^8) multiply
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      b = b >> 1;
    end
    return p;
  endfunction

  // S-box computed as inverse plus affine map
  function automatic logic [7:0] sub_b(input logic [7:0] x);
    logic [7:0] r, b;
    int e;
    r = 8'h01;
    b = x;
    e = 254;
    while (e != 0) begin
      if (e & 1) r = gmul(r, b);
      b = gmul(b, b);
      e >>= 1;
    end
    if (x == 8'h00) r = 8'h00;
    return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]} ^ 8'h63;
  endfunction

  // AES-128 encrypt, byte 0 in the top bits
  function automatic logic [127:0] aes_enc(input logic [127:0] k, input logic [127:0] pt);
    logic [7:0] w [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] k0, k1, k2, k3, tmp, rc, a0, a1, a2, a3;
    logic [127:0] o;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) w[i] = k[127-8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      k0 = w[i-4]; k1 = w[i-3]; k2 = w[i-2]; k3 = w[i-1];
      if ((i % 16) == 0) begin
        tmp = k0;
        k0 = sub_b(k1) ^ rc;
        k1 = sub_b(k2);
        k2 = sub_b(k3);
        k3 = sub_b(tmp);
        rc = gmul(rc, 8'h02);
      end
      w[i] = w[i-16] ^ k0; w[i+1] = w[i-15] ^ k1;
      w[i+2] = w[i-14] ^ k2; w[i+3] = w[i-13] ^ k3;
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ w[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int i = 0; i < 16; i++) s[i] = sub_b(s[i]);
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[r+4*c] = s[r+4*((c+r)%4)];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          s[4*c]   = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3;
          s[4*c+1] = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3;
          s[4*c+2] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3);
          s[4*c+3] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2);
        end
      end else begin
        s = t;
      end
      for (int i = 0; i < 16; i++) s[i] ^= w[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
  endfunction

  function automatic logic [127:0] blk_word(input int n);
    logic [127:0] v;
    v = '0;
    for (int i = 0; i < 16; i++) if (i < n) v[127-8*i -: 8] = msg_blk[i];
    return v;
  endfunction

  // Advance the predictor by one accepted request
  task automatic step_message(input logic [7:0] b, input bit present, input bit eom);
    logic [127:0] sub, blk;
    if (present) begin
      if (nbuf >= 16) begin
        chain = aes_enc(aes_key, chain ^ blk_word(16));
        nbuf = 0;
      end
      msg_blk[nbuf] = b;
      nbuf++;
    end
    if (eom) begin
      if (!l_valid) begin
        l_base = aes_enc(aes_key, 128'h0);
        l_valid = 1;
      end
      sub = gf_double(l_base);
      if (nbuf >= 16) begin
        blk = blk_word(16);
      end else begin
        blk = blk_word(nbuf);
        blk[127-8*nbuf -: 8] = CmacPad;
        sub = gf_double(sub);
      end
      tag_q.push_back(aes_enc(aes_key, blk ^ chain ^ sub));
      chain = '0;
      nbuf = 0;
    end
  endtask

  assign tags_pending = tag_q.size();

  always @(posedge clk) begin
    logic [127:0] exp_tag;
    if (!rst_n) begin
      aes_key = '0;
      chain = '0;
      nbuf = 0;
      l_valid = 0;
      tag_q.delete();
      fail_count = 0;
    end else begin
      // Key write starts a new message
      if (cfg_we) begin
        if (cfg_index == CfgKeyUpper) aes_key[127:64] = cfg_wdata;
        else aes_key[63:0] = cfg_wdata;
        chain = '0;
        nbuf = 0;
        l_valid = 0;
      end
      if (out_tvalid && out_tready) begin
        if (tag_q.size() == 0) begin
          $error("unexpected tag %h", out_tdata);
          fail_count++;
        end else begin
          exp_tag = tag_q.pop_front();
          if (out_tdata[63:0] != exp_tag[127:64]) begin
            $error("tag_upper: expected %h actual %h", exp_tag[127:64], out_tdata[63:0]);
            fail_count++;
          end
          if (out_tdata[127:64] != exp_tag[63:0]) begin
            $error("tag_lower: expected %h actual %h", exp_tag[63:0], out_tdata[127:64]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        step_message(in_tdata, in_tuser, in_tlast);
    end
  end

endmodule

[bench/tb_aes_cmac_tag_top.sv]
// Stimulus and verdict for the CMAC tag engine testbench.
module tb_aes_cmac_tag_top import acmac_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TimeoutCycles = 400000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tuser = 0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [127:0] out_tdata;
  logic         cfg_we = 0;
  logic         cfg_index = CfgKeyUpper;
  logic [63:0]  cfg_wdata = '0;
  int           fail_count;
  int           tags_pending;
  int           cycle_cnt = 0;
  bit           sink_hold = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  aes_cmac_tag_top dut (.*);

  aes_cmac_tag_checker chk (.*);

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > TimeoutCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // Result side stalls
  always @(posedge clk) begin
    if (!rst_n || sink_hold) out_tready <= 1'b1;
    else if ($urandom_range(0, 9) < 3) out_tready <= 1'b0;
    else if ($urandom_range(0, 29) == 0) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  // Send one request, with a random gap before it when idle is set
  task automatic send_req(input logic [7:0] b, input bit present, input bit eom, input bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= present;
    in_tlast <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tags_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_key(input logic idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_msg(input int len, input bit idle);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) send_req(8'($urandom), 1'b0, 1'b0, idle);
      send_req(8'($urandom), 1'b1, (i == len - 1), idle);
    end
    if (len == 0) send_req(8'($urandom), 1'b0, 1'b1, idle);
  endtask

  initial begin
    int sent;
    int len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key (all zero): empty message and byte extremes
    send_req(8'h00, 1'b0, 1'b0, 1'b0);
    send_req(8'h00, 1'b0, 1'b1, 1'b0);
    send_req(8'hff, 1'b1, 1'b1, 1'b0);
    send_req(8'h00, 1'b1, 1'b1, 1'b0);
    drain();

    // Known RFC key, then lengths 0, 16, 17, 15, 32
    write_key(CfgKeyUpper, 64'h2b7e151628aed2a6);
    write_key(~CfgKeyUpper, 64'habf7158809cf4f3c);
    send_msg(0, 1'b0);
    send_msg(16, 1'b0);
    drain();
    send_msg(17, 1'b1);
    send_msg(15, 1'b1);
    send_msg(32, 1'b0);
    drain();

    // All-ones key
    write_key(CfgKeyUpper, '1);
    write_key(~CfgKeyUpper, '1);
    send_msg(1, 1'b0);
    drain();

    // Random messages, mostly short, sometimes with new keys
    sent = 0;
    while (sent < 500) begin
      if ($urandom_range(0, 15) == 0) begin
        drain();
        write_key(CfgKeyUpper, {$urandom, $urandom});
        write_key(~CfgKeyUpper, {$urandom, $urandom});
      end
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = 16 * $urandom_range(1, 3);
        2: len = $urandom_range(33, 70);
        default: len = $urandom_range(1, 20);
      endcase
      send_msg(len, $urandom_range(0, 3) != 0);
      sent += len + 1;
      // Hold off until every tag is back, with the sink fully open
      if ($urandom_range(0, 19) == 0) begin
        sink_hold = 1;
        drain();
        sink_hold = 0;
      end
    end
    drain();

    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
